FILE: rtl/rzcp_pkg.sv
`default_nettype none

package rzcp_pkg;

    localparam int TIME_W     = 32;
    localparam int VAL_W      = 16;
    localparam int PER_W      = 24;
    localparam int CNT_W      = 13;
    localparam int SUM_W      = 48;
    localparam int MEAN_W     = 32;
    localparam int PROD_W     = PER_W + CNT_W;
    localparam int PH_W       = SUM_W + 2;
    localparam int DIVIDEND_W = 48;
    localparam int DIVISOR_W  = 16;
    localparam int STEP_W     = $clog2(DIVIDEND_W);

    localparam logic [PER_W-1:0] PERIOD_RESET = 24'd5851;
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int CNT_LIMIT       = 8191;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_OFF_START,
        ST_OFF_WAIT,
        ST_ADD,
        ST_SUB,
        ST_ACC,
        ST_FIN,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_SAT,
        ST_OUT
    } rzcp_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_start;
        logic div_mean;
        logic add;
        logic sub;
        logic acc;
        logic sat;
        logic load_out;
    } rzcp_cmd_t;

    typedef struct packed {
        logic cross_in;
        logic last_in;
        logic last;
        logic count_zero;
        logic div_done;
        logic out_free;
    } rzcp_status_t;

endpackage

`default_nettype wire

FILE: rtl/rzcp_div.sv
`default_nettype none

module rzcp_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [rzcp_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [rzcp_pkg::DIVISOR_W-1:0]  divisor,
    output logic                                 done,
    output logic [rzcp_pkg::DIVIDEND_W-1:0]      quotient
);
    import rzcp_pkg::*;

    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        shifted   = {rem_reg, quot_reg[DIVIDEND_W-1]};
        trial     = shifted - {1'b0, div_reg};
        fits      = ~trial[DIVISOR_W];
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("Divider started while a division was in progress.");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("Divider finished without having been busy.");
`endif

endmodule

`default_nettype wire

FILE: rtl/rzcp_dp.sv
`default_nettype none

module rzcp_dp #(
    parameter int MAX_SAMPLES = rzcp_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [rzcp_pkg::PER_W-1:0]        cfg_data,
    input  wire logic [rzcp_pkg::TIME_W-1:0]       sample_time,
    input  wire logic signed [rzcp_pkg::VAL_W-1:0] sample_value,
    input  wire logic                              last_sample,
    input  wire rzcp_pkg::rzcp_cmd_t               cmd,
    output rzcp_pkg::rzcp_status_t                 status,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic signed [rzcp_pkg::MEAN_W-1:0]     mean_phase,
    output logic [rzcp_pkg::CNT_W-1:0]             crossing_count,
    output logic                                   none_found
);
    import rzcp_pkg::*;

    localparam int CAP_INT = (MAX_SAMPLES < CNT_LIMIT) ? MAX_SAMPLES : CNT_LIMIT;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);
    localparam logic signed [SUM_W+2:0] SUM_HI = {4'b0000, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W+2:0] SUM_LO = {4'b1111, {(SUM_W-1){1'b0}}};
    localparam logic signed [DIVIDEND_W:0] MEAN_HI =
        {{(DIVIDEND_W-MEAN_W+2){1'b0}}, {(MEAN_W-1){1'b1}}};
    localparam logic signed [DIVIDEND_W:0] MEAN_LO =
        {{(DIVIDEND_W-MEAN_W+2){1'b1}}, {(MEAN_W-1){1'b0}}};

    logic [PER_W-1:0]         period_reg, period_next;
    logic [TIME_W-1:0]        prev_time_reg, prev_time_next;
    logic signed [VAL_W-1:0]  prev_value_reg, prev_value_next;
    logic                     have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     last_reg, last_next;
    logic [TIME_W-1:0]        base_time_reg, base_time_next;
    logic [TIME_W-1:0]        dt_reg, dt_next;
    logic [VAL_W-1:0]         negv_reg, negv_next;
    logic [DIVISOR_W-1:0]     den_reg, den_next;
    logic [DIVIDEND_W-1:0]    num_reg, num_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [PH_W-1:0]          add_reg, add_next;
    logic signed [PH_W-1:0]   phase_reg, phase_next;
    logic                     mean_neg_reg, mean_neg_next;
    logic signed [MEAN_W-1:0] mean_reg, mean_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [MEAN_W-1:0] mean_out_reg, mean_out_next;
    logic [CNT_W-1:0]         count_out_reg, count_out_next;
    logic                     none_out_reg, none_out_next;

    logic [DIVIDEND_W-1:0]    div_dividend;
    logic [DIVISOR_W-1:0]     div_divisor;
    logic [DIVIDEND_W-1:0]    div_quot;
    logic                     div_done;
    logic [DIVIDEND_W-1:0]    sum_mag;
    logic signed [SUM_W+2:0]  acc_wide;
    logic signed [DIVIDEND_W:0] mean_wide;
    logic                     out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // The divider serves the interpolation and the final mean in turn.
    assign sum_mag      = sum_reg[SUM_W-1] ? DIVIDEND_W'(-sum_reg) : DIVIDEND_W'(sum_reg);
    assign div_dividend = cmd.div_mean ? sum_mag : num_reg;
    assign div_divisor  = cmd.div_mean ? DIVISOR_W'(count_reg) : den_reg;

    rzcp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign acc_wide  = (SUM_W+3)'(sum_reg) + (SUM_W+3)'(phase_reg);
    assign mean_wide = mean_neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

    always_comb
    begin
        status.cross_in   = have_prev_reg && (prev_value_reg < 0) && (sample_value > 0)
                            && (count_reg < COUNT_CAP);
        status.last_in    = last_sample;
        status.last       = last_reg;
        status.count_zero = (count_reg == '0);
        status.div_done   = div_done;
        status.out_free   = out_free;
    end

    always_comb
    begin
        period_next     = cfg_write ? cfg_data : period_reg;
        prev_time_next  = prev_time_reg;
        prev_value_next = prev_value_reg;
        have_prev_next  = have_prev_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        last_next       = last_reg;
        base_time_next  = base_time_reg;
        dt_next         = dt_reg;
        negv_next       = negv_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        prod_next       = prod_reg;
        add_next        = add_reg;
        phase_next      = phase_reg;
        mean_neg_next   = mean_neg_reg;
        mean_next       = mean_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mean_out_next   = mean_out_reg;
        count_out_next  = count_out_reg;
        none_out_next   = none_out_reg;

        if (cmd.load)
        begin
            // Keep the earlier sample for the interpolation, then advance.
            base_time_next  = prev_time_reg;
            dt_next         = sample_time - prev_time_reg;
            negv_next       = VAL_W'(-prev_value_reg);
            den_next        = DIVISOR_W'(sample_value - prev_value_reg);
            last_next       = last_sample;
            prev_time_next  = sample_time;
            prev_value_next = sample_value;
            have_prev_next  = 1'b1;
        end
        if (cmd.mul)
        begin
            num_next  = DIVIDEND_W'(negv_reg) * DIVIDEND_W'(dt_reg);
            prod_next = PROD_W'(period_reg) * PROD_W'(count_reg);
        end
        if (cmd.div_start && cmd.div_mean)
        begin
            mean_neg_next = sum_reg[SUM_W-1];
        end
        if (cmd.add)
        begin
            add_next = PH_W'(base_time_reg) + PH_W'(div_quot);
        end
        if (cmd.sub)
        begin
            phase_next = $signed(add_reg - PH_W'(prod_reg));
        end
        if (cmd.acc)
        begin
            if (acc_wide > SUM_HI)
            begin
                sum_next = SUM_HI[SUM_W-1:0];
            end
            else if (acc_wide < SUM_LO)
            begin
                sum_next = SUM_LO[SUM_W-1:0];
            end
            else
            begin
                sum_next = acc_wide[SUM_W-1:0];
            end
            count_next = count_reg + 1'b1;
        end
        if (cmd.sat)
        begin
            if (mean_wide > MEAN_HI)
            begin
                mean_next = MEAN_HI[MEAN_W-1:0];
            end
            else if (mean_wide < MEAN_LO)
            begin
                mean_next = MEAN_LO[MEAN_W-1:0];
            end
            else
            begin
                mean_next = mean_wide[MEAN_W-1:0];
            end
        end
        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            mean_out_next   = (count_reg == '0) ? '0 : mean_reg;
            count_out_next  = count_reg;
            none_out_next   = (count_reg == '0);
            // The waveform is finished; start the next one from scratch.
            prev_time_next  = '0;
            prev_value_next = '0;
            have_prev_next  = 1'b0;
            count_next      = '0;
            sum_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RESET;
            prev_time_reg  <= '0;
            prev_value_reg <= '0;
            have_prev_reg  <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            period_reg     <= period_next;
            prev_time_reg  <= prev_time_next;
            prev_value_reg <= prev_value_next;
            have_prev_reg  <= have_prev_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_time_reg <= base_time_next;
        dt_reg        <= dt_next;
        negv_reg      <= negv_next;
        den_reg       <= den_next;
        num_reg       <= num_next;
        prod_reg      <= prod_next;
        add_reg       <= add_next;
        phase_reg     <= phase_next;
        mean_neg_reg  <= mean_neg_next;
        mean_reg      <= mean_next;
        mean_out_reg  <= mean_out_next;
        count_out_reg <= count_out_next;
        none_out_reg  <= none_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign mean_phase     = mean_out_reg;
    assign crossing_count = count_out_reg;
    assign none_found     = none_out_reg;

`ifndef NO_ASSERTIONS
    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_CAP)
        else $error("Crossing count ran past its cap.");

    a_cleared_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (count_reg == '0) && (sum_reg == '0) && !have_prev_reg)
        else $error("Waveform state not cleared after a result was loaded.");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && none_out_reg) |-> (mean_out_reg == '0) && (count_out_reg == '0))
        else $error("Empty waveform reported a nonzero mean or count.");
`endif

endmodule

`default_nettype wire

FILE: rtl/rzcp_ctrl.sv
`default_nettype none

module rzcp_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire rzcp_pkg::rzcp_status_t status,
    output rzcp_pkg::rzcp_cmd_t         cmd
);
    import rzcp_pkg::*;

    rzcp_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.cross_in)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (status.last_in)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MUL:        state_next = ST_OFF_START;
            ST_OFF_START:  state_next = ST_OFF_WAIT;
            ST_OFF_WAIT:   state_next = status.div_done ? ST_ADD : ST_OFF_WAIT;
            ST_ADD:        state_next = ST_SUB;
            ST_SUB:        state_next = ST_ACC;
            ST_ACC:        state_next = status.last ? ST_FIN : ST_IDLE;
            ST_FIN:        state_next = status.count_zero ? ST_OUT : ST_MEAN_START;
            ST_MEAN_START: state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:  state_next = status.div_done ? ST_SAT : ST_MEAN_WAIT;
            ST_SAT:        state_next = ST_OUT;
            ST_OUT:        state_next = status.out_free ? ST_IDLE : ST_OUT;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_MUL:        cmd.mul = 1'b1;
            ST_OFF_START:  cmd.div_start = 1'b1;
            ST_OFF_WAIT:   ;
            ST_ADD:        cmd.add = 1'b1;
            ST_SUB:        cmd.sub = 1'b1;
            ST_ACC:        cmd.acc = 1'b1;
            ST_FIN:        ;
            ST_MEAN_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mean  = 1'b1;
            end
            ST_MEAN_WAIT:  cmd.div_mean = 1'b1;
            ST_SAT:        cmd.sat = 1'b1;
            ST_OUT:        cmd.load_out = status.out_free;
            default:       ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rising_zero_crossing_phase.sv
`default_nettype none

// Rising zero-crossing phase estimator. Samples (time, amplitude) arrive one
// transaction at a time; last_sample marks the end of a waveform. Wherever a
// negative sample is followed by a positive one, up to min(MAX_SAMPLES, 8191)
// crossings, the crossing time is found by linear interpolation, folded by
// the crossing index times crossing_period and summed. The final sample
// yields one result: the mean folded crossing time (truncated toward zero,
// saturated to 32 bits), the crossing count, and none_found when nothing
// crossed. Other non-last samples are taken straight from idle; a crossing
// steps through multiply, divide, add, subtract and accumulate. A waveform's
// end divides for the mean and saturates it (skipped when nothing crossed),
// then waits while the output register is still full. The interpolation and
// the final mean share one one-bit-per-cycle 48-bit divider (48 steps). The
// result sits in an output register, so the next waveform may start while it
// waits. crossing_period may be written only while the block is idle.
module rising_zero_crossing_phase #(
    parameter int MAX_SAMPLES = rzcp_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [rzcp_pkg::PER_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [rzcp_pkg::TIME_W-1:0]       sample_time,
    input  wire logic signed [rzcp_pkg::VAL_W-1:0] sample_value,
    input  wire logic                              last_sample,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [rzcp_pkg::MEAN_W-1:0]     mean_phase,
    output logic [rzcp_pkg::CNT_W-1:0]             crossing_count,
    output logic                                   none_found
);
    import rzcp_pkg::*;

    rzcp_cmd_t    cmd;
    rzcp_status_t status;

    rzcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rzcp_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .sample_time    (sample_time),
        .sample_value   (sample_value),
        .last_sample    (last_sample),
        .cmd            (cmd),
        .status         (status),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .mean_phase     (mean_phase),
        .crossing_count (crossing_count),
        .none_found     (none_found)
    );

endmodule

`default_nettype wire
